### src/sse_pkg.sv
package sse_pkg;

    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_FRAC_BITS  = 16;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_POS   = 2'd1;
    localparam logic [1:0] OP_DER   = 2'd2;

    localparam logic [1:0] MODE_LIN = 2'd0;
    localparam logic [1:0] MODE_CR  = 2'd1;
    localparam logic [1:0] MODE_BEZ = 2'd2;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef struct packed {
        logic signed [31:0] y;
        logic signed [31:0] x;
    } t_point;

    typedef struct packed {
        logic [1:0] mode;
        logic       deriv;
    } t_sel;

    typedef struct packed {
        logic vld;
        logic eval;
        logic err;
        logic cr;
    } t_tag;

endpackage

### src/sse_point_banks.sv
module sse_point_banks
    import sse_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic        i_clk,
    input  logic        i_wr_en,
    input  logic [9:0]  i_wr_addr,
    input  t_point      i_wr_data,
    input  logic        i_rd_en,
    input  logic [10:0] i_rd_base,
    output t_point      o_pt [4]
);

    localparam int BANK_DEPTH = (MAX_POINTS + 3) / 4;
    localparam int ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    t_point     bank_q [4];
    logic [1:0] r_lo;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        t_point           r_mem [BANK_DEPTH];
        t_point           r_q;
        logic [1:0]       off;
        logic [11:0]      rd_addr;
        logic [ROW_W-1:0] rd_row;
        logic [ROW_W-1:0] wr_row;

        assign off     = 2'(b) - i_rd_base[1:0];
        assign rd_addr = {1'b0, i_rd_base} + {10'b0, off};
        assign rd_row  = ROW_W'(rd_addr >> 2);
        assign wr_row  = ROW_W'(i_wr_addr >> 2);

        always_ff @(posedge i_clk) begin
            if (i_wr_en && i_wr_addr[1:0] == 2'(b)) begin
                r_mem[wr_row] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_q <= r_mem[rd_row];
            end
        end

        assign bank_q[b] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_lo <= i_rd_base[1:0];
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_rot
        assign o_pt[k] = bank_q[r_lo + 2'(k)];
    end

endmodule

### src/sse_weight_gen.sv
module sse_weight_gen
    import sse_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [FRAC_BITS:0]          i_u,
    input  t_sel                        i_sel,
    output logic signed [FRAC_BITS+5:0] o_w [4]
);

    localparam int U_W = FRAC_BITS + 1;
    localparam int W_W = FRAC_BITS + 6;
    localparam int P_W = 2 * U_W;
    localparam logic [P_W-1:0] HALF = P_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [W_W-1:0] TONE = W_W'(1) << FRAC_BITS;

    logic [U_W-1:0] r_t2;
    logic [U_W-1:0] r_u2;
    logic [U_W-1:0] r_t3;
    logic [U_W-1:0] r_t2b;
    logic [U_W-1:0] r_u3;
    t_sel           r_sel2;
    t_sel           r_sel3;
    logic [P_W-1:0] sq;
    logic [P_W-1:0] cube;

    logic signed [W_W-1:0] su, s2, s3;
    logic signed [W_W-1:0] u2x, u3x, u4, u6, u8, u10, u12;
    logic signed [W_W-1:0] s2_2, s2_3, s2_4, s2_5, s2_6, s2_9, s3_3;
    logic signed [W_W-1:0] t_2, t_3;
    logic signed [W_W-1:0] n_w [4];
    logic signed [W_W-1:0] r_w [4];

    assign sq   = P_W'(i_u) * P_W'(i_u);
    assign cube = P_W'(r_t2) * P_W'(r_u2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t2   <= U_W'((sq + HALF) >> FRAC_BITS);
            r_u2   <= i_u;
            r_sel2 <= i_sel;
            r_t3   <= U_W'((cube + HALF) >> FRAC_BITS);
            r_t2b  <= r_t2;
            r_u3   <= r_u2;
            r_sel3 <= r_sel2;
            r_w    <= n_w;
        end
    end

    assign su   = $signed({{(W_W-U_W){1'b0}}, r_u3});
    assign s2   = $signed({{(W_W-U_W){1'b0}}, r_t2b});
    assign s3   = $signed({{(W_W-U_W){1'b0}}, r_t3});
    assign u2x  = su <<< 1;
    assign u3x  = su + u2x;
    assign u4   = su <<< 2;
    assign u6   = u3x <<< 1;
    assign u8   = su <<< 3;
    assign u10  = u8 + u2x;
    assign u12  = u6 <<< 1;
    assign s2_2 = s2 <<< 1;
    assign s2_3 = s2 + s2_2;
    assign s2_4 = s2 <<< 2;
    assign s2_5 = s2_4 + s2;
    assign s2_6 = s2_3 <<< 1;
    assign s2_9 = s2_3 + s2_6;
    assign s3_3 = s3 + (s3 <<< 1);
    assign t_2  = TONE <<< 1;
    assign t_3  = TONE + t_2;

    always_comb begin
        n_w[0] = '0;
        n_w[1] = '0;
        n_w[2] = '0;
        n_w[3] = '0;
        unique case (r_sel3.mode)
            MODE_LIN: begin
                if (r_sel3.deriv) begin
                    n_w[0] = -TONE;
                    n_w[1] = TONE;
                end else begin
                    n_w[0] = TONE - su;
                    n_w[1] = su;
                end
            end
            MODE_CR: begin
                if (r_sel3.deriv) begin
                    n_w[0] = u4 - s2_3 - TONE;
                    n_w[1] = s2_9 - u10;
                    n_w[2] = u8 + TONE - s2_9;
                    n_w[3] = s2_3 - u2x;
                end else begin
                    n_w[0] = s2_2 - s3 - su;
                    n_w[1] = s3_3 - s2_5 + t_2;
                    n_w[2] = s2_4 + su - s3_3;
                    n_w[3] = s3 - s2;
                end
            end
            MODE_BEZ: begin
                if (r_sel3.deriv) begin
                    n_w[0] = u6 - t_3 - s2_3;
                    n_w[1] = t_3 - u12 + s2_9;
                    n_w[2] = u6 - s2_9;
                    n_w[3] = s2_3;
                end else begin
                    n_w[0] = TONE - u3x + s2_3 - s3;
                    n_w[1] = u3x - s2_6 + s3_3;
                    n_w[2] = s2_3 - s3_3;
                    n_w[3] = s3;
                end
            end
            default: begin
                n_w[0] = '0;
            end
        endcase
    end

    assign o_w = r_w;

endmodule

### src/sse_mac.sv
module sse_mac
    import sse_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  t_point                       i_pt [4],
    input  logic signed [FRAC_BITS+5:0]  i_w [4],
    input  logic                         i_cr,
    output logic signed [FRAC_BITS+39:0] o_acc_x,
    output logic signed [FRAC_BITS+39:0] o_acc_y
);

    localparam int W_W   = FRAC_BITS + 6;
    localparam int P_W   = W_W + 32;
    localparam int ACC_W = W_W + 34;
    localparam logic signed [ACC_W-1:0] RND_STD = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] RND_CR  = ACC_W'(1) <<< FRAC_BITS;

    t_point                  r_pt2 [4];
    t_point                  r_pt3 [4];
    t_point                  r_pt4 [4];
    logic signed [31:0]      xe [4];
    logic signed [31:0]      ye [4];
    logic signed [P_W-1:0]   r_px [4];
    logic signed [P_W-1:0]   r_py [4];
    logic signed [ACC_W-1:0] r_sx [2];
    logic signed [ACC_W-1:0] r_sy [2];
    logic signed [ACC_W-1:0] r_ax;
    logic signed [ACC_W-1:0] r_ay;
    logic signed [ACC_W-1:0] rnd;

    for (genvar k = 0; k < 4; k++) begin : g_mask
        assign xe[k] = (i_w[k] == '0) ? '0 : r_pt4[k].x;
        assign ye[k] = (i_w[k] == '0) ? '0 : r_pt4[k].y;
    end

    assign rnd = i_cr ? RND_CR : RND_STD;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pt2 <= i_pt;
            r_pt3 <= r_pt2;
            r_pt4 <= r_pt3;
            for (int k = 0; k < 4; k++) begin
                r_px[k] <= P_W'(i_w[k]) * P_W'(xe[k]);
                r_py[k] <= P_W'(i_w[k]) * P_W'(ye[k]);
            end
            r_sx[0] <= ACC_W'(r_px[0]) + ACC_W'(r_px[1]);
            r_sx[1] <= ACC_W'(r_px[2]) + ACC_W'(r_px[3]);
            r_sy[0] <= ACC_W'(r_py[0]) + ACC_W'(r_py[1]);
            r_sy[1] <= ACC_W'(r_py[2]) + ACC_W'(r_py[3]);
            r_ax    <= r_sx[0] + r_sx[1] + rnd;
            r_ay    <= r_sy[0] + r_sy[1] + rnd;
        end
    end

    assign o_acc_x = r_ax;
    assign o_acc_y = r_ay;

endmodule

### src/spline_segment_evaluator.sv
// Channel  Direction  Handshake          Payload
// in       input      i_valid / o_stall  i_op, i_index, i_px, i_py, i_tparam
// out      output     o_valid / i_stall  o_rx, o_ry, o_status
// config   input      psel / penable     paddr, pwdata, prdata
//
// One item is accepted per cycle while o_stall is low; each item yields one result.
// Four interleaved point banks deliver the four control points of a segment in one read.
// A point write is seen by the very next item.
// Reset clears the configuration registers and the pipeline; the point store is not cleared.
// A stalled result holds the whole pipeline, and o_stall follows it in the same cycle.
module spline_segment_evaluator
    import sse_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic [9:0]         i_index,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    input  logic [16:0]        i_tparam,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_rx,
    output logic signed [31:0] o_ry,
    output logic               o_status
);

    localparam int U_W   = FRAC_BITS + 1;
    localparam int W_W   = FRAC_BITS + 6;
    localparam int ACC_W = W_W + 34;
    localparam int TW    = (U_W > 17) ? U_W : 17;
    localparam logic [TW-1:0] TONE = TW'(1) << FRAC_BITS;
    localparam logic [16:0]   MAXP = 17'(MAX_POINTS);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sd2147483648);

    logic [1:0]  r_curve_mode;
    logic [10:0] r_point_count;
    logic        cfg_wr;

    logic        adv;
    logic        in_fire;
    logic        is_eval;
    logic        seg_ok;
    logic [11:0] n_lim;
    logic [11:0] idx12;
    logic [TW-1:0] tp_ext;
    logic [U_W-1:0] u_in;
    logic [10:0] rd_base;
    logic        wr_en;
    t_tag        tag_in;
    t_sel        sel_in;

    t_tag           r_tag [1:7];
    logic [U_W-1:0] r_u1;
    t_sel           r_sel1;

    t_point                  pts [4];
    logic signed [W_W-1:0]   wts [4];
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic signed [ACC_W-1:0] sh_x;
    logic signed [ACC_W-1:0] sh_y;

    logic               r_out_vld;
    logic signed [31:0] r_rx;
    logic signed [31:0] r_ry;
    logic               r_status;

    function automatic logic [31:0] f_sat(input logic signed [ACC_W-1:0] v);
        logic [31:0] res;
        if (v > SAT_HI) begin
            res = 32'h7FFF_FFFF;
        end else if (v < SAT_LO) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_mode  <= MODE_LIN;
            r_point_count <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MODE:  r_curve_mode  <= pwdata[1:0];
                REG_COUNT: r_point_count <= pwdata[10:0];
                default:   r_curve_mode  <= r_curve_mode;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MODE:  prdata = {30'b0, r_curve_mode};
            REG_COUNT: prdata = {21'b0, r_point_count};
            default:   prdata = '0;
        endcase
    end

    assign adv     = !(r_out_vld && i_stall);
    assign o_stall = !adv;
    assign in_fire = i_valid && adv;

    assign n_lim = (17'(r_point_count) < MAXP) ? {1'b0, r_point_count} : 12'(MAX_POINTS);
    assign idx12 = {2'b0, i_index};

    always_comb begin
        unique case (r_curve_mode)
            MODE_LIN: seg_ok = (idx12 + 12'd1) < n_lim;
            MODE_CR:  seg_ok = (i_index != '0) && ((idx12 + 12'd2) < n_lim);
            MODE_BEZ: seg_ok = (idx12 + 12'd3) < n_lim;
            default:  seg_ok = 1'b0;
        endcase
    end

    assign is_eval = (i_op == OP_POS) || (i_op == OP_DER);
    assign tag_in  = '{vld: in_fire, eval: is_eval && seg_ok, err: is_eval && !seg_ok,
                       cr: r_curve_mode == MODE_CR};
    assign sel_in  = '{mode: r_curve_mode, deriv: i_op == OP_DER};
    assign tp_ext  = TW'(i_tparam);
    assign u_in    = U_W'((tp_ext > TONE) ? TONE : tp_ext);
    assign rd_base = (r_curve_mode == MODE_CR) ? ({1'b0, i_index} - 11'd1) : {1'b0, i_index};
    assign wr_en   = in_fire && (i_op == OP_WRITE) && ({7'b0, i_index} < MAXP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 7; s++) begin
                r_tag[s] <= '0;
            end
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_tag[1] <= tag_in;
            for (int s = 2; s <= 7; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
            r_out_vld <= r_tag[7].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_u1     <= u_in;
            r_sel1   <= sel_in;
            r_rx     <= r_tag[7].eval ? f_sat(sh_x) : '0;
            r_ry     <= r_tag[7].eval ? f_sat(sh_y) : '0;
            r_status <= r_tag[7].err;
        end
    end

    assign sh_x = r_tag[7].cr ? (acc_x >>> (FRAC_BITS + 1)) : (acc_x >>> FRAC_BITS);
    assign sh_y = r_tag[7].cr ? (acc_y >>> (FRAC_BITS + 1)) : (acc_y >>> FRAC_BITS);

    sse_point_banks #(
        .MAX_POINTS(MAX_POINTS)
    ) u_banks (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(i_index),
        .i_wr_data('{y: i_py, x: i_px}),
        .i_rd_en  (in_fire),
        .i_rd_base(rd_base),
        .o_pt     (pts)
    );

    sse_weight_gen #(
        .FRAC_BITS(FRAC_BITS)
    ) u_weights (
        .i_clk(i_clk),
        .i_en (adv),
        .i_u  (r_u1),
        .i_sel(r_sel1),
        .o_w  (wts)
    );

    sse_mac #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mac (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_pt   (pts),
        .i_w    (wts),
        .i_cr   (r_tag[6].cr),
        .o_acc_x(acc_x),
        .o_acc_y(acc_y)
    );

    assign o_valid  = r_out_vld;
    assign o_rx     = r_rx;
    assign o_ry     = r_ry;
    assign o_status = r_status;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_rx == '0 && o_ry == '0)
        else $error("An out-of-range result carries nonzero coordinates.");

    a_last_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_tag[7].vld |=> o_valid)
        else $error("An item in the last stage was lost on its way out.");

    a_write_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_op == OP_WRITE |=> r_tag[1].vld && !r_tag[1].eval && !r_tag[1].err)
        else $error("A write item entered the pipeline as an evaluation.");

endmodule
